### rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, codes and helper functions of the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

	localparam int CODE_DIGITS_DEF = 4;

	localparam int KEY_W    = 4;
	localparam int STATUS_W = 3;
	localparam int TRIES_W  = 4;
	localparam int SEED_W   = 16;
	localparam int BCD_W    = 16;
	localparam int ENTRY_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd10;
	localparam logic [KEY_W-1:0] KEY_ENTER = 4'd11;

	localparam logic [STATUS_W-1:0] ST_DIGIT   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_WRONG   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LOCKED  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 2'd1;

	localparam logic [TRIES_W-1:0] MAX_TRIES_RST = 4'd3;
	localparam logic [TRIES_W-1:0] FAILED_MAX    = 4'd15;
	localparam logic [SEED_W-1:0]  SEED_RST      = 16'd44257;
	localparam logic [SEED_W-1:0]  LFSR_TAPS     = 16'hB400;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic              seed_load;
		logic [SEED_W-1:0] seed;
		logic              draw;
	} kcl_gen_ctl_t;

	// Galois step, right shift.
	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] r;
		r = {1'b0, s[SEED_W-1:1]};
		if (s[0]) begin
			r = r ^ LFSR_TAPS;
		end
		return r;
	endfunction

	// Remainder by ten: parity from bit 0, residue mod 5 from nibble sums (16 = 1 mod 5).
	function automatic digit_t mod10(input logic [15:0] n);
		logic [5:0] s;
		logic [4:0] t;
		s = 6'(n[3:0]) + 6'(n[7:4]) + 6'(n[11:8]) + 6'(n[15:12]);
		t = 5'(s[5:4]) + 5'(s[3:0]);
		if (t >= 5'd15) begin
			t = t - 5'd15;
		end
		if (t >= 5'd10) begin
			t = t - 5'd10;
		end
		if (t >= 5'd5) begin
			t = t - 5'd5;
		end
		if (t[0] == n[0]) begin
			return 4'(t);
		end
		return 4'(t) + 4'd5;
	endfunction

endpackage

### rtl/kcl_ifs.sv
// ----------------------------------------------------------------------------
// kcl channel interfaces
// Key beat, result beat and register write channels of the code lock.
// ----------------------------------------------------------------------------
interface kcl_key_if;
	logic                      valid;
	logic                      ready;
	logic [kcl_pkg::KEY_W-1:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink   (input valid, input key_code, output ready);
endinterface

interface kcl_res_if;
	logic                         valid;
	logic                         ready;
	logic [kcl_pkg::STATUS_W-1:0] status;
	logic [kcl_pkg::ENTRY_W-1:0]  digits_entered;
	logic [kcl_pkg::TRIES_W-1:0]  tries_left;
	logic [kcl_pkg::BCD_W-1:0]    new_code;
	logic                         locked;

	modport source (output valid, output status, output digits_entered, output tries_left,
		output new_code, output locked, input ready);
	modport sink   (input valid, input status, input digits_entered, input tries_left,
		input new_code, input locked, output ready);
endinterface

interface kcl_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [kcl_pkg::CFG_IDX_W-1:0] index;
	logic [kcl_pkg::SEED_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/keypad_code_lock.sv
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad combination lock with try counting, permanent lockout and fresh
// random codes after every successful entry.
// ----------------------------------------------------------------------------
// One key beat in, one result beat out. A key is taken into an input register,
// handled combinationally against the entry, code and try state, and its
// result lands in an output register, so a new key can be accepted every cycle
// while the result register is free or being drained. The next code is drawn
// from the LFSR ahead of time (CODE_DIGITS steps, combinationally) and committed
// on a grant. Register writes take effect at once and are accepted every cycle;
// index 0 sets max_tries, index 1 reloads the LFSR seed (zero loads one).
module keypad_code_lock #(
	parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	kcl_key_if.sink   key,
	kcl_res_if.source res,
	kcl_cfg_if.sink   cfg
);

	logic                              cfg_wr;
	logic [kcl_pkg::TRIES_W-1:0]       max_tries_q;
	kcl_pkg::kcl_gen_ctl_t             gen_ctl;
	kcl_pkg::digit_t [CODE_DIGITS-1:0] fresh_code;
	logic                              draw;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tries_q <= kcl_pkg::MAX_TRIES_RST;
		end else if (cfg_wr && cfg.index == kcl_pkg::REG_MAX_TRIES) begin
			max_tries_q <= cfg.data[kcl_pkg::TRIES_W-1:0];
		end
	end

	assign gen_ctl.seed_load = cfg_wr && cfg.index == kcl_pkg::REG_RANDOM_SEED;
	assign gen_ctl.seed      = cfg.data;
	assign gen_ctl.draw      = draw;

	kcl_codegen #(
		.CODE_DIGITS(CODE_DIGITS)
	) u_codegen (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (gen_ctl),
		.fresh_code(fresh_code)
	);

	kcl_engine #(
		.CODE_DIGITS(CODE_DIGITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key),
		.res       (res),
		.max_tries (max_tries_q),
		.fresh_code(fresh_code),
		.draw      (draw)
	);

endmodule

### rtl/kcl_codegen.sv
// ----------------------------------------------------------------------------
// kcl_codegen
// LFSR and digit draw: offers the next fresh code, advances on a grant, reloads on a seed write.
// ----------------------------------------------------------------------------
module kcl_codegen #(
	parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  kcl_pkg::kcl_gen_ctl_t                    ctl,
	output kcl_pkg::digit_t [CODE_DIGITS-1:0]        fresh_code
);

	logic [kcl_pkg::SEED_W-1:0] lfsr_q;
	logic [kcl_pkg::SEED_W-1:0] lfsr_next;

	always_comb begin
		logic [kcl_pkg::SEED_W-1:0] s;
		s = lfsr_q;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			s = kcl_pkg::lfsr_step(s);
			fresh_code[i] = kcl_pkg::mod10(s);
		end
		lfsr_next = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= kcl_pkg::SEED_RST;
		end else if (ctl.seed_load) begin
			// avoid the all-zero lockup
			lfsr_q <= (ctl.seed == '0) ? kcl_pkg::SEED_W'(1) : ctl.seed;
		end else if (ctl.draw) begin
			lfsr_q <= lfsr_next;
		end
	end

endmodule

### rtl/kcl_engine.sv
// ----------------------------------------------------------------------------
// kcl_engine
// Input register, entry and try bookkeeping, and the result register.
// ----------------------------------------------------------------------------
module kcl_engine #(
	parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	kcl_key_if.sink                              key,
	kcl_res_if.source                            res,
	input  logic [kcl_pkg::TRIES_W-1:0]          max_tries,
	input  kcl_pkg::digit_t [CODE_DIGITS-1:0]    fresh_code,
	output logic                                 draw
);

	localparam int CNT_W = $clog2(CODE_DIGITS + 2);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);
	localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(CODE_DIGITS + 1);

	logic                          vld_s1;
	logic [kcl_pkg::KEY_W-1:0]     key_s1;
	logic                          advance;

	kcl_pkg::digit_t [CODE_DIGITS-1:0] entry_q, entry_d;
	kcl_pkg::digit_t [CODE_DIGITS-1:0] stored_q;
	logic [CNT_W-1:0]              count_q, count_d;
	logic [kcl_pkg::TRIES_W-1:0]   failed_q, failed_d;
	logic                          lock_q, lock_d;

	logic [kcl_pkg::STATUS_W-1:0]  status_d;
	logic [kcl_pkg::BCD_W-1:0]     bcd;
	logic                          match;

	logic                          vld_s2;
	logic [kcl_pkg::STATUS_W-1:0]  status_s2;
	logic [kcl_pkg::ENTRY_W-1:0]   entered_s2;
	logic [kcl_pkg::TRIES_W-1:0]   tries_s2;
	logic [kcl_pkg::BCD_W-1:0]     code_s2;
	logic                          locked_s2;

	// process the held beat when the result register is free or being drained
	assign advance   = vld_s1 && (!vld_s2 || res.ready);
	assign key.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (key.ready) begin
			vld_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key.ready && key.valid) begin
			key_s1 <= key.key_code;
		end
	end

	always_comb begin
		match = (count_q == CNT_FULL);
		for (int i = 0; i < CODE_DIGITS; i++) begin
			if (entry_q[i] != stored_q[i]) begin
				match = 1'b0;
			end
		end
	end

	// last four drawn digits as BCD, first digit highest
	always_comb begin
		bcd = '0;
		for (int k = 0; k < 4; k++) begin
			if (k < CODE_DIGITS) begin
				bcd[4*k +: 4] = fresh_code[(CODE_DIGITS - 1 - k) % CODE_DIGITS];
			end
		end
	end

	always_comb begin
		logic [kcl_pkg::TRIES_W-1:0] failed_inc;
		entry_d    = entry_q;
		count_d    = count_q;
		failed_d   = failed_q;
		lock_d     = lock_q;
		status_d   = kcl_pkg::ST_IGNORED;
		draw       = 1'b0;
		failed_inc = (failed_q == kcl_pkg::FAILED_MAX) ? failed_q
			: failed_q + kcl_pkg::TRIES_W'(1);
		if (lock_q || key_s1 > kcl_pkg::KEY_ENTER) begin
			status_d = kcl_pkg::ST_IGNORED;
		end else if (key_s1 < kcl_pkg::KEY_CLEAR) begin
			status_d = kcl_pkg::ST_DIGIT;
			if (count_q < CNT_FULL) begin
				for (int i = 0; i < CODE_DIGITS; i++) begin
					if (count_q == CNT_W'(i)) begin
						entry_d[i] = key_s1;
					end
				end
				count_d = count_q + CNT_W'(1);
			end else begin
				count_d = CNT_OVER;
			end
		end else if (key_s1 == kcl_pkg::KEY_CLEAR) begin
			status_d = kcl_pkg::ST_CLEARED;
			entry_d  = '0;
			count_d  = '0;
		end else begin
			if (match) begin
				status_d = kcl_pkg::ST_GRANTED;
				draw     = advance;
			end else begin
				failed_d = failed_inc;
				if (failed_inc >= max_tries) begin
					lock_d   = 1'b1;
					status_d = kcl_pkg::ST_LOCKED;
				end else begin
					status_d = kcl_pkg::ST_WRONG;
				end
			end
			entry_d = '0;
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			count_q  <= '0;
			failed_q <= '0;
			lock_q   <= 1'b0;
			for (int i = 0; i < CODE_DIGITS; i++) begin
				stored_q[i] <= 4'((i + 1) % 10);
			end
		end else if (advance) begin
			entry_q  <= entry_d;
			count_q  <= count_d;
			failed_q <= failed_d;
			lock_q   <= lock_d;
			if (draw) begin
				stored_q <= fresh_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (res.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2  <= status_d;
			entered_s2 <= kcl_pkg::ENTRY_W'(count_d);
			tries_s2   <= (max_tries > failed_d) ? max_tries - failed_d : '0;
			code_s2    <= (status_d == kcl_pkg::ST_GRANTED) ? bcd : '0;
			locked_s2  <= lock_d;
		end
	end

	assign res.valid          = vld_s2;
	assign res.status         = status_s2;
	assign res.digits_entered = entered_s2;
	assign res.tries_left     = tries_s2;
	assign res.new_code       = code_s2;
	assign res.locked         = locked_s2;

endmodule

### dv/keypad_code_lock_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_code_lock_tb
// Self-checking bench for the keypad code lock. Key beats go out in random
// bursts. Each result beat is checked against a cycle-free model of the lock
// that tracks the entry, the stored code, the try count and the code LFSR. The
// stimulus plans mostly correct codes from a second copy of that model, so
// grants and fresh codes keep coming. Wrong tries are budgeted so that the
// lockout is only reached at the very end.
// ----------------------------------------------------------------------------
module keypad_code_lock_tb;

	localparam int CD       = kcl_pkg::CODE_DIGITS_DEF;
	localparam int HOLD_AT  = 500;
	localparam int HOLD_LEN = 400;
	localparam int SETTLE   = 4;

	typedef struct packed {
		logic [kcl_pkg::TRIES_W-1:0]  max_tries;
		logic [kcl_pkg::SEED_W-1:0]   lfsr;
		kcl_pkg::digit_t [CD-1:0]     entry;
		logic [kcl_pkg::ENTRY_W-1:0]  count;
		kcl_pkg::digit_t [CD-1:0]     code;
		logic [kcl_pkg::TRIES_W-1:0]  fails;
		logic                         locked;
	} lock_state_t;

	typedef struct packed {
		logic [kcl_pkg::STATUS_W-1:0] status;
		logic [kcl_pkg::ENTRY_W-1:0]  digits_entered;
		logic [kcl_pkg::TRIES_W-1:0]  tries_left;
		logic [kcl_pkg::BCD_W-1:0]    new_code;
		logic                         locked;
	} lock_result_t;

	logic clk;
	logic arst_n;

	kcl_key_if key_if ();
	kcl_res_if res_if ();
	kcl_cfg_if cfg_if ();

	keypad_code_lock i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	lock_state_t                plan;
	lock_state_t                live;
	logic [kcl_pkg::KEY_W-1:0]  pending_keys[$];
	lock_result_t               owed_results[$];

	int n_keys;
	int n_results;
	int n_errors;
	int n_planned;
	int status_tally[8];

	int burst_left;
	int gap_left;
	int rx_mode;
	int rx_left;
	int hold_left;
	bit hold_done;

	function automatic lock_state_t reset_state();
		lock_state_t s;
		s = '0;
		s.max_tries = kcl_pkg::MAX_TRIES_RST;
		s.lfsr      = kcl_pkg::SEED_RST;
		for (int i = 0; i < CD; i++) begin
			s.code[i] = kcl_pkg::digit_t'((i + 1) % 10);
		end
		return s;
	endfunction

	function automatic void load_register(inout lock_state_t s,
		input logic [kcl_pkg::CFG_IDX_W-1:0] idx, input logic [kcl_pkg::SEED_W-1:0] v);
		case (idx)
			kcl_pkg::REG_MAX_TRIES: begin
				s.max_tries = v[kcl_pkg::TRIES_W-1:0];
			end
			kcl_pkg::REG_RANDOM_SEED: begin
				// all-zero seed would stick, so load one instead
				s.lfsr = (v == '0) ? kcl_pkg::SEED_W'(1) : v;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic bit entry_opens(input lock_state_t s);
		return (s.count == kcl_pkg::ENTRY_W'(CD)) && (s.entry == s.code);
	endfunction

	function automatic lock_result_t press_key(inout lock_state_t s,
		input logic [kcl_pkg::KEY_W-1:0] k);
		lock_result_t    r;
		kcl_pkg::digit_t d;
		logic            lsb;
		r = '0;
		r.status = kcl_pkg::ST_IGNORED;
		if (s.locked || k > kcl_pkg::KEY_ENTER) begin
			r.status = kcl_pkg::ST_IGNORED;
		end else if (k < kcl_pkg::KEY_CLEAR) begin
			if (s.count < kcl_pkg::ENTRY_W'(CD)) begin
				s.entry[s.count[$clog2(CD)-1:0]] = k;
				s.count = s.count + 1'b1;
			end else begin
				s.count = kcl_pkg::ENTRY_W'(CD + 1);
			end
			r.status = kcl_pkg::ST_DIGIT;
		end else if (k == kcl_pkg::KEY_CLEAR) begin
			s.entry = '0;
			s.count = '0;
			r.status = kcl_pkg::ST_CLEARED;
		end else begin
			if (entry_opens(s)) begin
				// draw the next code, one LFSR step per digit, first digit on top
				for (int i = 0; i < CD; i++) begin
					lsb = s.lfsr[0];
					s.lfsr = s.lfsr >> 1;
					if (lsb) begin
						s.lfsr = s.lfsr ^ kcl_pkg::LFSR_TAPS;
					end
					d = kcl_pkg::digit_t'(s.lfsr % 16'd10);
					s.code[i] = d;
					r.new_code = (r.new_code << 4) | kcl_pkg::BCD_W'(d);
				end
				r.status = kcl_pkg::ST_GRANTED;
			end else begin
				if (s.fails != kcl_pkg::FAILED_MAX) begin
					s.fails = s.fails + 1'b1;
				end
				if (s.fails >= s.max_tries) begin
					s.locked = 1'b1;
					r.status = kcl_pkg::ST_LOCKED;
				end else begin
					r.status = kcl_pkg::ST_WRONG;
				end
			end
			s.entry = '0;
			s.count = '0;
		end
		r.digits_entered = s.count;
		r.tries_left     = (s.max_tries > s.fails) ? s.max_tries - s.fails : '0;
		r.locked         = s.locked;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (n_errors < 40) begin
			$display("ERROR @%0t result %0d: %s", $time, n_results, msg);
		end
		n_errors++;
	endtask

	// ------------------------------------------------------------------
	// stimulus planning
	// ------------------------------------------------------------------
	task automatic plan_key(input logic [kcl_pkg::KEY_W-1:0] k);
		lock_result_t r;
		r = press_key(plan, k);
		pending_keys.push_back(k);
		status_tally[r.status]++;
		if (r.status != kcl_pkg::ST_IGNORED) begin
			n_planned++;
		end
	endtask

	// enter only when it opens or a wrong try still leaves room before lockout
	task automatic plan_enter();
		if (entry_opens(plan) || int'(plan.fails) + 1 < int'(plan.max_tries)) begin
			plan_key(kcl_pkg::KEY_ENTER);
		end else begin
			plan_key(kcl_pkg::KEY_CLEAR);
		end
	endtask

	task automatic plan_code(input bit typo);
		int              slip;
		kcl_pkg::digit_t d;
		if (plan.count != '0) begin
			plan_key(kcl_pkg::KEY_CLEAR);
		end
		slip = typo ? $urandom_range(0, CD - 1) : -1;
		for (int i = 0; i < CD; i++) begin
			d = plan.code[i];
			if (i == slip) begin
				d = kcl_pkg::digit_t'((d + $urandom_range(1, 9)) % 10);
			end
			if ($urandom_range(0, 9) == 0) begin
				plan_key(kcl_pkg::KEY_W'($urandom_range(kcl_pkg::KEY_ENTER + 1, 15)));
			end
			plan_key(d);
		end
		plan_enter();
	endtask

	task automatic plan_random(input int n_items);
		int goal;
		int sel;
		logic [kcl_pkg::KEY_W-1:0] k;
		goal = n_planned + n_items;
		while (n_planned < goal) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				plan_code(1'b0);
			end else if (sel < 55) begin
				plan_code(1'b1);
			end else if (sel < 70) begin
				repeat ($urandom_range(1, 6)) plan_key(kcl_pkg::KEY_W'($urandom_range(0, 9)));
				plan_key(kcl_pkg::KEY_CLEAR);
			end else if (sel < 80) begin
				repeat ($urandom_range(0, 6)) plan_key(kcl_pkg::KEY_W'($urandom_range(0, 9)));
				plan_enter();
			end else begin
				k = kcl_pkg::KEY_W'($urandom_range(0, 15));
				if (k == kcl_pkg::KEY_ENTER) begin
					plan_enter();
				end else begin
					plan_key(k);
				end
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_keys.size() != 0 || owed_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [kcl_pkg::CFG_IDX_W-1:0] idx,
		input logic [kcl_pkg::SEED_W-1:0] v);
		wait_idle();
		cfg_if.index <= idx;
		cfg_if.data  <= v;
		cfg_if.valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		load_register(live, idx, v);
		load_register(plan, idx, v);
	endtask

	// ------------------------------------------------------------------
	// clock, reset, sequence of phases
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int lo;
		arst_n          = 1'b0;
		key_if.valid    = 1'b0;
		key_if.key_code = '0;
		res_if.ready    = 1'b0;
		cfg_if.valid    = 1'b0;
		cfg_if.index    = '0;
		cfg_if.data     = '0;
		plan = reset_state();
		live = reset_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening sequence on reset settings: open, ignored keys, clear,
		// overlong entry, short entry, open again with the fresh code
		plan_code(1'b0);
		plan_key(kcl_pkg::KEY_W'(12));
		plan_key(kcl_pkg::KEY_W'(15));
		plan_key(kcl_pkg::KEY_W'(9));
		plan_key(kcl_pkg::KEY_W'(0));
		plan_key(kcl_pkg::KEY_CLEAR);
		for (int i = 0; i < CD; i++) begin
			plan_key(plan.code[i]);
		end
		plan_key(kcl_pkg::KEY_W'(9));
		plan_enter();
		plan_key(kcl_pkg::KEY_W'(0));
		plan_enter();
		plan_code(1'b0);

		write_reg(kcl_pkg::REG_MAX_TRIES, kcl_pkg::SEED_W'(15));
		write_reg(kcl_pkg::REG_RANDOM_SEED, '0);
		plan_random(200);

		write_reg(kcl_pkg::REG_RANDOM_SEED, 16'hFFFF);
		write_reg(kcl_pkg::REG_MAX_TRIES, kcl_pkg::SEED_W'(1));
		plan_random(120);

		write_reg(kcl_pkg::REG_MAX_TRIES, '0);
		plan_random(80);

		write_reg(kcl_pkg::REG_MAX_TRIES, kcl_pkg::SEED_W'(15));
		write_reg(kcl_pkg::REG_RANDOM_SEED, kcl_pkg::SEED_W'($urandom_range(1, 65535)));
		plan_random(350);

		lo = int'(plan.fails) + 2;
		if (lo > 15) begin
			lo = 15;
		end
		write_reg(kcl_pkg::REG_RANDOM_SEED, kcl_pkg::SEED_W'($urandom_range(1, 65535)));
		write_reg(kcl_pkg::REG_MAX_TRIES, kcl_pkg::SEED_W'($urandom_range(lo, 15)));
		plan_random(250);

		// zero tries allowed: the next wrong try locks for good, then all is ignored
		write_reg(kcl_pkg::REG_MAX_TRIES, '0);
		plan_key(kcl_pkg::KEY_W'(5));
		plan_key(kcl_pkg::KEY_ENTER);
		plan_code(1'b0);
		repeat (20) plan_key(kcl_pkg::KEY_W'($urandom_range(0, 15)));

		wait_idle();
		repeat (8) @(posedge clk);
		$display("summary: %0d keys, %0d digits, %0d clears, %0d grants, %0d wrong, %0d lockout",
			n_keys, status_tally[kcl_pkg::ST_DIGIT], status_tally[kcl_pkg::ST_CLEARED],
			status_tally[kcl_pkg::ST_GRANTED], status_tally[kcl_pkg::ST_WRONG],
			status_tally[kcl_pkg::ST_LOCKED]);
		$display("summary: %0d ignored keys, tries limits 0/1/15/random, seeds 0/ffff/random",
			status_tally[kcl_pkg::ST_IGNORED]);
		if (n_errors == 0) begin
			$display("keypad_code_lock test passed");
		end else begin
			$display("keypad_code_lock test failed");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("ERROR: run did not complete, %0d results still owed", owed_results.size());
		$display("keypad_code_lock test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// key driver: bursts of beats with gaps, gaps only start after a beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			key_if.valid    <= 1'b0;
			key_if.key_code <= '0;
			burst_left      = 0;
			gap_left        = 0;
		end else begin
			if (key_if.valid && key_if.ready) begin
				owed_results.push_back(press_key(live, key_if.key_code));
				void'(pending_keys.pop_front());
				n_keys <= n_keys + 1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left = burst_left - 1;
				end
			end
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				key_if.valid <= 1'b0;
			end else if (pending_keys.size() != 0) begin
				key_if.valid    <= 1'b1;
				key_if.key_code <= pending_keys[0];
			end else begin
				key_if.valid <= 1'b0;
			end
		end
	end

	// one long receiver hold-off while keys keep coming, to fill the block
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_keys >= HOLD_AT && pending_keys.size() > 16) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------
	// result monitor and receiver stall pattern
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		lock_result_t want;
		bit take;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			rx_mode      = 0;
			rx_left      = 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("result beat with none owed, status %0d",
						res_if.status));
				end else begin
					want = owed_results.pop_front();
					if (res_if.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							res_if.status, want.status));
					if (res_if.digits_entered !== want.digits_entered)
						report_mismatch($sformatf("digits_entered %0d, want %0d",
							res_if.digits_entered, want.digits_entered));
					if (res_if.tries_left !== want.tries_left)
						report_mismatch($sformatf("tries_left %0d, want %0d",
							res_if.tries_left, want.tries_left));
					if (res_if.new_code !== want.new_code)
						report_mismatch($sformatf("new_code %h, want %h",
							res_if.new_code, want.new_code));
					if (res_if.locked !== want.locked)
						report_mismatch($sformatf("locked %b, want %b",
							res_if.locked, want.locked));
				end
				n_results <= n_results + 1;
			end
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(10, 150);
			end else begin
				rx_left = rx_left - 1;
			end
			case (rx_mode)
				0: take = 1'b1;
				1: take = 1'($urandom_range(0, 1));
				2: take = ($urandom_range(0, 3) == 0);
				default: take = !res_if.ready;
			endcase
			res_if.ready <= take && (hold_left == 0);
		end
	end

endmodule
